@@ hdl/sva_pkg.sv @@
// Shared constants, widths and code types of the sound voice allocator.
package sva_pkg;

   localparam int VOICES           = 8;
   localparam int MAX_STATIC       = 16;
   localparam int FRAC_BITS        = 16;
   localparam int MAX_WAVE_SAMPLES = 1048576;

   localparam int ENT_W    = 16;
   localparam int CHAN_W   = 3;
   localparam int LEN_W    = 21;
   localparam int LOOP_W   = 20;
   localparam int STEP_W   = 19;
   localparam int POS_W    = LEN_W + FRAC_BITS;
   localparam int PROD_W   = POS_W + STEP_W;
   localparam int VIDX_W   = 5;
   localparam int IGN_W    = 16;
   localparam int ACT_W    = $clog2(VOICES + 1);
   localparam int ST_CNT_W = $clog2(MAX_STATIC + 1);
   localparam int DYN_IW   = $clog2(VOICES);
   localparam int ST_IW    = (MAX_STATIC > 1) ? $clog2(MAX_STATIC) : 1;
   localparam int IX_W     = (ST_CNT_W > ACT_W) ? ST_CNT_W : ACT_W;
   localparam int CSR_AW   = 2;
   localparam int CSR_DW   = 32;

   typedef enum logic [1:0] {
      REQ_START  = 2'd0,
      REQ_STOP   = 2'd1,
      REQ_STATIC = 2'd2,
      REQ_TICK   = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      STS_OK          = 3'd0,
      STS_DROPPED     = 3'd1,
      STS_NO_LOOP     = 3'd2,
      STS_STATIC_FULL = 3'd3,
      STS_STOP_MISS   = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_MATCH,
      ST_MUL_A,
      ST_MUL_B,
      ST_CMP,
      ST_PLACE,
      ST_STATIC,
      ST_ADV,
      ST_WRAP,
      ST_DONE
   } state_type;

endpackage

@@ hdl/sound_voice_allocator.sv @@
// Voice allocator with stealing, a looping static table and frame advance.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+----------------------------------------
//   req     | in        | req_valid / req_ready  | type, entity, chan, length, loop, step
//   rsp     | out       | rsp_valid / rsp_ready  | status, voice, counts, ignored statics
//   csr     | in/out    | APB, pready tied high  | listener_entity at address 0
//
// One item at a time through a small sequencer around one shared 37x19
// multiplier. A start scans the voices for a matching entity and channel (for a
// nonzero channel), then searches the voices for the least time left, skipping
// listener voices for a foreign sound; a stop scans for a match; a tick advances
// every voice and static entry and wraps looping ones into their loop. The input
// reopens in the cycle after the result load. Synchronous reset frees all voices
// and empties the static table. A stalled rsp side holds the sequencer in its
// last state until the output register frees up.
module sound_voice_allocator (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_type,
   input  logic [sva_pkg::ENT_W-1:0]     req_entity,
   input  logic [sva_pkg::CHAN_W-1:0]    req_chan_num,
   input  logic [sva_pkg::LEN_W-1:0]     req_wave_length,
   input  logic [sva_pkg::LOOP_W-1:0]    req_loop_point,
   input  logic                          req_has_loop,
   input  logic [sva_pkg::STEP_W-1:0]    req_step_q16,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [2:0]                    rsp_status,
   output logic [sva_pkg::VIDX_W-1:0]    rsp_voice_index,
   output logic [3:0]                    rsp_dyn_count,
   output logic [4:0]                    rsp_static_count,
   output logic [sva_pkg::IGN_W-1:0]     rsp_ignored_statics,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [sva_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [sva_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic [sva_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                          csr_pready
);

   localparam int POS_W = sva_pkg::POS_W;
   localparam int FB    = sva_pkg::FRAC_BITS;

   // Configuration register
   logic [sva_pkg::ENT_W-1:0] listener_ff;

   // Captured request, clamped at accept
   sva_pkg::req_kind_type      kind_ff;
   logic [sva_pkg::ENT_W-1:0]  ent_ff;
   logic [sva_pkg::CHAN_W-1:0] chan_ff;
   logic [sva_pkg::LEN_W-1:0]  len_ff;
   logic [sva_pkg::LOOP_W-1:0] loop_ff;
   logic                       looping_ff;
   logic [sva_pkg::STEP_W-1:0] step_ff;

   // Voice state
   logic [sva_pkg::VOICES-1:0] dyn_active_ff;
   logic [sva_pkg::ENT_W-1:0]  dyn_entity_ff   [sva_pkg::VOICES];
   logic [sva_pkg::CHAN_W-1:0] dyn_chan_ff     [sva_pkg::VOICES];
   logic [POS_W-1:0]           dyn_position_ff [sva_pkg::VOICES];
   logic [sva_pkg::LEN_W-1:0]  dyn_length_ff   [sva_pkg::VOICES];
   logic [sva_pkg::LOOP_W-1:0] dyn_loop_ff     [sva_pkg::VOICES];
   logic                       dyn_has_loop_ff [sva_pkg::VOICES];
   logic [sva_pkg::STEP_W-1:0] dyn_step_ff     [sva_pkg::VOICES];
   logic [POS_W-1:0]           st_position_ff  [sva_pkg::MAX_STATIC];
   logic [sva_pkg::LEN_W-1:0]  st_length_ff    [sva_pkg::MAX_STATIC];
   logic [sva_pkg::LOOP_W-1:0] st_loop_ff      [sva_pkg::MAX_STATIC];
   logic [sva_pkg::STEP_W-1:0] st_step_ff      [sva_pkg::MAX_STATIC];
   logic [sva_pkg::ST_CNT_W-1:0] st_count_ff, st_count_in;
   logic [sva_pkg::IGN_W-1:0]    ignored_ff, ignored_in;

   // Sequencer
   sva_pkg::state_type state_ff, state_in;
   logic [sva_pkg::IX_W-1:0]   ix_ff, ix_in;
   logic                       is_static_ff, is_static_in;
   logic                       found_ff, found_in;
   logic [sva_pkg::DYN_IW-1:0] sel_ff, sel_in;
   logic [POS_W-1:0]           best_r_ff, best_r_in;
   logic [sva_pkg::STEP_W-1:0] best_s_ff, best_s_in;
   logic [sva_pkg::PROD_W-1:0] mul_ff, mul_in, p1_ff, p1_in;
   logic [POS_W-1:0]           acc_ff, acc_in;
   logic [POS_W-1:0]           span_ff, span_in;
   sva_pkg::status_type        status_ff, status_in;
   logic [sva_pkg::VIDX_W-1:0] vidx_ff, vidx_in;

   // Output register
   logic                       rsp_valid_ff;
   logic [2:0]                 rsp_status_ff;
   logic [sva_pkg::VIDX_W-1:0] rsp_vidx_ff;
   logic [3:0]                 rsp_nact_ff;
   logic [4:0]                 rsp_nst_ff;
   logic [sva_pkg::IGN_W-1:0]  rsp_ign_ff;

   // Write strobes from the datapath block
   logic                       dyn_load, dyn_pos_we, dyn_clear, st_load, st_pos_we, rsp_load;
   logic [POS_W-1:0]           pos_wdata;

   // Operand selection
   logic [sva_pkg::DYN_IW-1:0] dix;
   logic [sva_pkg::ST_IW-1:0]  six;
   logic [POS_W-1:0]           cur_pos, endq, loopq, sum, r_cur;
   logic [sva_pkg::LEN_W-1:0]  cur_len;
   logic [sva_pkg::LOOP_W-1:0] cur_loop;
   logic [sva_pkg::STEP_W-1:0] cur_step, s_cur;
   logic                       cur_looping, cur_active, skip, hit, dyn_last, accept;
   logic [POS_W-1:0]           mul_a;
   logic [sva_pkg::STEP_W-1:0] mul_b;

   // Clamped request fields
   logic [sva_pkg::LEN_W-1:0]  len_c;
   logic [sva_pkg::LOOP_W-1:0] loop_c;
   logic [sva_pkg::STEP_W-1:0] step_c;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == sva_pkg::ST_IDLE);

   // Clamp length into range, loop below the end, zero step to one
   always_comb begin
      if (req_wave_length == '0) begin
         len_c = sva_pkg::LEN_W'(1);
      end else if (req_wave_length > sva_pkg::LEN_W'(sva_pkg::MAX_WAVE_SAMPLES)) begin
         len_c = sva_pkg::LEN_W'(sva_pkg::MAX_WAVE_SAMPLES);
      end else begin
         len_c = req_wave_length;
      end
      if ({1'b0, req_loop_point} >= len_c) begin
         loop_c = sva_pkg::LOOP_W'(len_c - sva_pkg::LEN_W'(1));
      end else begin
         loop_c = req_loop_point;
      end
      step_c = (req_step_q16 == '0) ? sva_pkg::STEP_W'(1) : req_step_q16;
   end

   // Voice under the pointer
   assign dix = ix_ff[sva_pkg::DYN_IW-1:0];
   assign six = ix_ff[sva_pkg::ST_IW-1:0];

   always_comb begin
      if (is_static_ff) begin
         cur_pos     = st_position_ff[six];
         cur_len     = st_length_ff[six];
         cur_loop    = st_loop_ff[six];
         cur_step    = st_step_ff[six];
         cur_looping = 1'b1;
         cur_active  = 1'b1;
      end else begin
         cur_pos     = dyn_position_ff[dix];
         cur_len     = dyn_length_ff[dix];
         cur_loop    = dyn_loop_ff[dix];
         cur_step    = dyn_step_ff[dix];
         cur_looping = dyn_has_loop_ff[dix];
         cur_active  = dyn_active_ff[dix];
      end
   end

   assign endq  = {cur_len, {FB{1'b0}}};
   assign loopq = POS_W'({cur_loop, {FB{1'b0}}});
   assign sum   = cur_pos + POS_W'(cur_step);
   // An idle voice counts as zero time left
   assign r_cur = cur_active ? (endq - cur_pos) : '0;
   assign s_cur = cur_active ? cur_step : sva_pkg::STEP_W'(1);
   assign skip  = cur_active && (dyn_entity_ff[dix] == listener_ff) && (ent_ff != listener_ff);
   assign hit   = cur_active && (dyn_entity_ff[dix] == ent_ff) && (dyn_chan_ff[dix] == chan_ff);
   assign dyn_last = (ix_ff == sva_pkg::IX_W'(sva_pkg::VOICES - 1));

   // Shared multiplier: remaining time cross products
   assign mul_a  = (state_ff == sva_pkg::ST_MUL_B) ? best_r_ff : r_cur;
   assign mul_b  = (state_ff == sva_pkg::ST_MUL_B) ? s_cur : best_s_ff;
   assign mul_in = sva_pkg::PROD_W'(mul_a) * sva_pkg::PROD_W'(mul_b);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sva_pkg::ST_IDLE: begin
            if (accept) state_in = sva_pkg::ST_DECODE;
         end
         sva_pkg::ST_DECODE: begin
            unique case (kind_ff)
               sva_pkg::REQ_START:  state_in = (chan_ff != '0) ? sva_pkg::ST_MATCH
                                                              : sva_pkg::ST_MUL_A;
               sva_pkg::REQ_STOP:   state_in = sva_pkg::ST_MATCH;
               sva_pkg::REQ_STATIC: state_in = sva_pkg::ST_STATIC;
               default:             state_in = sva_pkg::ST_ADV;
            endcase
         end
         sva_pkg::ST_MATCH: begin
            if (hit) begin
               state_in = (kind_ff == sva_pkg::REQ_STOP) ? sva_pkg::ST_DONE
                                                         : sva_pkg::ST_PLACE;
            end else if (dyn_last) begin
               state_in = (kind_ff == sva_pkg::REQ_STOP) ? sva_pkg::ST_DONE
                                                         : sva_pkg::ST_MUL_A;
            end
         end
         sva_pkg::ST_MUL_A: begin
            if (!skip)         state_in = sva_pkg::ST_MUL_B;
            else if (dyn_last) state_in = sva_pkg::ST_PLACE;
         end
         sva_pkg::ST_MUL_B: state_in = sva_pkg::ST_CMP;
         sva_pkg::ST_CMP: begin
            state_in = dyn_last ? sva_pkg::ST_PLACE : sva_pkg::ST_MUL_A;
         end
         sva_pkg::ST_PLACE:  state_in = sva_pkg::ST_DONE;
         sva_pkg::ST_STATIC: state_in = sva_pkg::ST_DONE;
         sva_pkg::ST_ADV: begin
            if (is_static_ff && ({1'b0, ix_ff} >= {1'b0, sva_pkg::IX_W'(st_count_ff)})) begin
               state_in = sva_pkg::ST_DONE;
            end else if (cur_active && sum >= endq && cur_looping) begin
               state_in = sva_pkg::ST_WRAP;
            end
         end
         sva_pkg::ST_WRAP: begin
            if (acc_ff < endq) state_in = sva_pkg::ST_ADV;
         end
         sva_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) state_in = sva_pkg::ST_IDLE;
         end
         default: state_in = sva_pkg::ST_IDLE;
      endcase
   end

   // Datapath and write strobes
   always_comb begin
      ix_in        = ix_ff;
      is_static_in = is_static_ff;
      found_in     = found_ff;
      sel_in       = sel_ff;
      best_r_in    = best_r_ff;
      best_s_in    = best_s_ff;
      p1_in        = p1_ff;
      acc_in       = acc_ff;
      span_in      = span_ff;
      status_in    = status_ff;
      vidx_in      = vidx_ff;
      st_count_in  = st_count_ff;
      ignored_in   = ignored_ff;
      dyn_load     = 1'b0;
      dyn_pos_we   = 1'b0;
      dyn_clear    = 1'b0;
      st_load      = 1'b0;
      st_pos_we    = 1'b0;
      rsp_load     = 1'b0;
      pos_wdata    = sum;
      unique case (state_ff)
         sva_pkg::ST_DECODE: begin
            ix_in        = '0;
            is_static_in = 1'b0;
            found_in     = 1'b0;
            status_in    = sva_pkg::STS_OK;
            vidx_in      = '0;
         end
         sva_pkg::ST_MATCH: begin
            if (hit) begin
               if (kind_ff == sva_pkg::REQ_STOP) begin
                  dyn_clear = 1'b1;
                  vidx_in   = sva_pkg::VIDX_W'(dix);
               end else begin
                  found_in = 1'b1;
                  sel_in   = dix;
               end
            end else if (dyn_last) begin
               ix_in = '0;
               if (kind_ff == sva_pkg::REQ_STOP) status_in = sva_pkg::STS_STOP_MISS;
            end else begin
               ix_in = ix_ff + sva_pkg::IX_W'(1);
            end
         end
         sva_pkg::ST_MUL_A: begin
            // skip listener voices that a foreign sound may not steal
            if (skip) ix_in = ix_ff + sva_pkg::IX_W'(1);
         end
         sva_pkg::ST_MUL_B: p1_in = mul_ff;
         sva_pkg::ST_CMP: begin
            if (!found_ff || p1_ff < mul_ff) begin
               found_in  = 1'b1;
               sel_in    = dix;
               best_r_in = r_cur;
               best_s_in = s_cur;
            end
            ix_in = ix_ff + sva_pkg::IX_W'(1);
         end
         sva_pkg::ST_PLACE: begin
            if (found_ff) begin
               dyn_load = 1'b1;
               vidx_in  = sva_pkg::VIDX_W'(sel_ff);
            end else begin
               status_in = sva_pkg::STS_DROPPED;
            end
         end
         sva_pkg::ST_STATIC: begin
            if (!looping_ff) begin
               status_in = sva_pkg::STS_NO_LOOP;
               if (ignored_ff != '1) ignored_in = ignored_ff + sva_pkg::IGN_W'(1);
            end else if (st_count_ff >= sva_pkg::ST_CNT_W'(sva_pkg::MAX_STATIC)) begin
               status_in = sva_pkg::STS_STATIC_FULL;
            end else begin
               st_load     = 1'b1;
               vidx_in     = sva_pkg::VIDX_W'(sva_pkg::VOICES) + sva_pkg::VIDX_W'(st_count_ff);
               st_count_in = st_count_ff + sva_pkg::ST_CNT_W'(1);
            end
         end
         sva_pkg::ST_ADV: begin
            if (!(is_static_ff && ({1'b0, ix_ff} >= {1'b0, sva_pkg::IX_W'(st_count_ff)}))) begin
               if (cur_active && sum >= endq && cur_looping) begin
                  acc_in  = sum;
                  span_in = endq - loopq;
               end else begin
                  if (cur_active && sum < endq) begin
                     dyn_pos_we = !is_static_ff;
                     st_pos_we  = is_static_ff;
                  end else if (cur_active) begin
                     dyn_clear = 1'b1;
                  end
                  // step to the next voice, static table after the dynamic ones
                  if (!is_static_ff && dyn_last) begin
                     ix_in        = '0;
                     is_static_in = 1'b1;
                  end else begin
                     ix_in = ix_ff + sva_pkg::IX_W'(1);
                  end
               end
            end
         end
         sva_pkg::ST_WRAP: begin
            if (acc_ff >= endq) begin
               acc_in = acc_ff - span_ff;
            end else begin
               pos_wdata  = acc_ff;
               dyn_pos_we = !is_static_ff;
               st_pos_we  = is_static_ff;
               if (!is_static_ff && dyn_last) begin
                  ix_in        = '0;
                  is_static_in = 1'b1;
               end else begin
                  ix_in = ix_ff + sva_pkg::IX_W'(1);
               end
            end
         end
         sva_pkg::ST_DONE: rsp_load = !rsp_valid_ff || rsp_ready;
         default: begin
         end
      endcase
   end

   // Sequencer and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= sva_pkg::ST_IDLE;
         dyn_active_ff <= '0;
         st_count_ff   <= '0;
         ignored_ff    <= '0;
         listener_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         st_count_ff <= st_count_in;
         ignored_ff  <= ignored_in;
         if (csr_psel && csr_penable && csr_pwrite && (csr_paddr == '0)) begin
            listener_ff <= csr_pwdata[sva_pkg::ENT_W-1:0];
         end
         if (dyn_load)  dyn_active_ff[sel_ff] <= 1'b1;
         if (dyn_clear) dyn_active_ff[dix]    <= 1'b0;
         if (rsp_load)                rsp_valid_ff <= 1'b1;
         else if (rsp_ready)          rsp_valid_ff <= 1'b0;
      end
   end

   // Payload and working registers
   always_ff @(posedge clock) begin
      ix_ff        <= ix_in;
      is_static_ff <= is_static_in;
      found_ff     <= found_in;
      sel_ff       <= sel_in;
      best_r_ff    <= best_r_in;
      best_s_ff    <= best_s_in;
      mul_ff       <= mul_in;
      p1_ff        <= p1_in;
      acc_ff       <= acc_in;
      span_ff      <= span_in;
      status_ff    <= status_in;
      vidx_ff      <= vidx_in;
      if (accept) begin
         kind_ff    <= sva_pkg::req_kind_type'(req_type);
         ent_ff     <= req_entity;
         chan_ff    <= req_chan_num;
         len_ff     <= len_c;
         loop_ff    <= loop_c;
         looping_ff <= req_has_loop;
         step_ff    <= step_c;
      end
      if (dyn_load) begin
         dyn_entity_ff[sel_ff]   <= ent_ff;
         dyn_chan_ff[sel_ff]     <= chan_ff;
         dyn_position_ff[sel_ff] <= '0;
         dyn_length_ff[sel_ff]   <= len_ff;
         dyn_loop_ff[sel_ff]     <= loop_ff;
         dyn_has_loop_ff[sel_ff] <= looping_ff;
         dyn_step_ff[sel_ff]     <= step_ff;
      end
      if (dyn_pos_we) dyn_position_ff[dix] <= pos_wdata;
      if (st_load) begin
         st_position_ff[st_count_ff[sva_pkg::ST_IW-1:0]] <= '0;
         st_length_ff[st_count_ff[sva_pkg::ST_IW-1:0]]   <= len_ff;
         st_loop_ff[st_count_ff[sva_pkg::ST_IW-1:0]]     <= loop_ff;
         st_step_ff[st_count_ff[sva_pkg::ST_IW-1:0]]     <= step_ff;
      end
      if (st_pos_we) st_position_ff[six] <= pos_wdata;
      if (rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_vidx_ff   <= vidx_ff;
         rsp_nact_ff   <= 4'($countones(dyn_active_ff));
         rsp_nst_ff    <= 5'(st_count_ff);
         rsp_ign_ff    <= ignored_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_voice_index     = rsp_vidx_ff;
   assign rsp_dyn_count       = rsp_nact_ff;
   assign rsp_static_count    = rsp_nst_ff;
   assign rsp_ignored_statics = rsp_ign_ff;
   assign csr_pready          = 1'b1;
   assign csr_prdata          = {{(sva_pkg::CSR_DW - sva_pkg::ENT_W){1'b0}}, listener_ff};

   // Static table never overfills
   a_static_bound: assert property (@(posedge clock) disable iff (reset)
      st_count_ff <= sva_pkg::ST_CNT_W'(sva_pkg::MAX_STATIC))
      else $error("static count past table size");

   // Wrap accumulator never drops below the loop start
   a_wrap_floor: assert property (@(posedge clock) disable iff (reset)
      state_ff == sva_pkg::ST_WRAP |-> acc_ff >= loopq)
      else $error("wrap fell below loop point");

   // An accepted item closes the input until its result is formed
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("second item taken while busy");

   // Ignored-static count only grows
   a_ign_mono: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> ignored_ff >= $past(ignored_ff))
      else $error("ignored count went down");

endmodule
